FILE: design/wcmp_pkg.sv
// Package for the waveform column min/peak reducer.
// Holds field widths, register indexes, reset values and the divide-by-255 reciprocal.
// No dependencies; every other file in the block refers to it by scoped names.
package wcmp_pkg;

   localparam int SampleWidth  = 16;
   localparam int RowWidth     = 12;
   localparam int AmpWidth     = 15;
   localparam int SpcWidth     = 16;
   localparam int ColCntWidth  = 13;
   localparam int ColIdxWidth  = 12;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 16;

   // Largest column count the column counter can address
   localparam logic [ColCntWidth-1:0] MaxColumns = 13'd4096;

   // ceil(2^31 / 255): exact floor division for products below 2^23
   localparam logic [23:0] Recip255  = 24'd8421505;
   localparam int          RecipShift = 31;

   // Bias that turns an arithmetic shift by 15 into truncation toward zero
   localparam logic signed [30:0] TruncBias = 31'sd32767;

   // Reset values of the configuration registers
   localparam logic [RowWidth-1:0]    HeightReset    = 12'd100;
   localparam logic [AmpWidth-1:0]    AmplitudeReset = 15'd50;
   localparam logic [SpcWidth-1:0]    SpcReset       = 16'd256;
   localparam logic [ColCntWidth-1:0] ColCountReset  = 13'd640;
   localparam logic                   FormatReset    = 1'b1;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_HEIGHT     = 3'd0,
      CSR_AMPLITUDE  = 3'd1,
      CSR_SPC        = 3'd2,
      CSR_COL_COUNT  = 3'd3,
      CSR_FORMAT     = 3'd4
   } csr_index_type;

   typedef enum logic {
      FMT_U8  = 1'b0,
      FMT_S16 = 1'b1
   } sample_format_type;

endpackage

FILE: design/wcmp_if.sv
// Channel interfaces for the waveform column min/peak reducer: sample input,
// column result output and register write port. Depends on wcmp_pkg.
interface wcmp_req_if;
   logic                               valid;
   logic                               ready;
   logic [wcmp_pkg::SampleWidth-1:0]   sample_word;

   modport source (output valid, output sample_word, input ready);
   modport sink   (input valid, input sample_word, output ready);
endinterface

interface wcmp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [wcmp_pkg::RowWidth-1:0]      column_min;
   logic [wcmp_pkg::RowWidth-1:0]      column_peak;
   logic                               last_column;

   modport source (output valid, output column_min, output column_peak,
                   output last_column, input ready);
   modport sink   (input valid, input column_min, input column_peak,
                   input last_column, output ready);
endinterface

interface wcmp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [wcmp_pkg::CsrIdxWidth-1:0]   index;
   logic [wcmp_pkg::CsrDataWidth-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/waveform_column_min_peak.sv
// Top level of the waveform column min/peak reducer: maps samples to display rows and
// folds them into per-column minimum and peak. Depends on wcmp_pkg and wcmp_if.
//
//   port       dir   carries                                      width
//   req_bus    in    sample_word                                  16
//   rsp_bus    out   column_min, column_peak, last_column         12, 12, 1
//   csr_bus    in    index (0..4), data                           3, 16
//
// One sample per cycle sustained unless a stalled result backs up. The accepting edge loads
// the input register, then signed product and quotient registers; the fold takes the sample
// into running min/peak and, at a column end, the result register. The two multipliers set
// the depth. A stalled result only blocks a sample that ends a column; other stages fill.
// Reset clears all valid flags, counters and the running peak, loads the running minimum
// with the reset height; registers take their defaults. Register writes are always accepted.
module waveform_column_min_peak (
   input  logic             clock,
   input  logic             reset,
   wcmp_req_if.sink         req_bus,
   wcmp_rsp_if.source       rsp_bus,
   wcmp_csr_if.sink         csr_bus
);

   // Configuration registers
   logic [wcmp_pkg::RowWidth-1:0]    height_ff;
   logic [wcmp_pkg::AmpWidth-1:0]    amplitude_ff;
   logic [wcmp_pkg::SpcWidth-1:0]    spc_ff;
   logic [wcmp_pkg::ColCntWidth-1:0] col_count_ff;
   wcmp_pkg::sample_format_type      format_ff;

   // Pipeline registers
   logic                             a_valid_ff, a_valid_in;
   logic [wcmp_pkg::SampleWidth-1:0] a_sample_ff;
   logic                             b_valid_ff, b_valid_in;
   logic signed [30:0]               b_product_ff, b_product_in;
   logic                             c_valid_ff, c_valid_in;
   logic signed [16:0]               c_quot_ff, c_quot_in;

   // Fold state
   logic [wcmp_pkg::SpcWidth-1:0]    sample_in_col_ff, sample_in_col_in;
   logic [wcmp_pkg::ColIdxWidth-1:0] col_index_ff, col_index_in;
   logic [wcmp_pkg::RowWidth-1:0]    run_min_ff, run_min_in;
   logic [wcmp_pkg::RowWidth-1:0]    run_peak_ff, run_peak_in;

   // Result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [wcmp_pkg::RowWidth-1:0]    rsp_min_ff, rsp_min_in;
   logic [wcmp_pkg::RowWidth-1:0]    rsp_peak_ff, rsp_peak_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic req_accept, a_free, b_free, c_free, fold_go, col_ends, col_last;

   // ---------------------------------------------------------------- registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff    <= wcmp_pkg::HeightReset;
         amplitude_ff <= wcmp_pkg::AmplitudeReset;
         spc_ff       <= wcmp_pkg::SpcReset;
         col_count_ff <= wcmp_pkg::ColCountReset;
         format_ff    <= wcmp_pkg::sample_format_type'(wcmp_pkg::FormatReset);
      end else if (csr_bus.valid) begin
         unique case (wcmp_pkg::csr_index_type'(csr_bus.index))
            wcmp_pkg::CSR_HEIGHT:    height_ff    <= csr_bus.data[wcmp_pkg::RowWidth-1:0];
            wcmp_pkg::CSR_AMPLITUDE: amplitude_ff <= csr_bus.data[wcmp_pkg::AmpWidth-1:0];
            wcmp_pkg::CSR_SPC:       spc_ff       <= csr_bus.data[wcmp_pkg::SpcWidth-1:0];
            wcmp_pkg::CSR_COL_COUNT: col_count_ff <= csr_bus.data[wcmp_pkg::ColCntWidth-1:0];
            wcmp_pkg::CSR_FORMAT:    format_ff    <= wcmp_pkg::sample_format_type'(csr_bus.data[0]);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   assign c_free  = !c_valid_ff || fold_go;
   assign b_free  = !b_valid_ff || c_free;
   assign a_free  = !a_valid_ff || b_free;
   assign req_bus.ready = a_free;
   assign req_accept    = req_bus.valid && a_free;

   assign a_valid_in = req_accept || (a_valid_ff && !b_free);
   assign b_valid_in = (a_valid_ff && b_free) || (b_valid_ff && !c_free);
   assign c_valid_in = (b_valid_ff && c_free) || (c_valid_ff && !fold_go);

   // ---------------------------------------------------------------- product stage
   logic signed [16:0] samp_op;
   logic signed [15:0] amp_op;
   logic signed [32:0] prod_full;

   always_comb begin
      if (format_ff == wcmp_pkg::FMT_U8) begin
         samp_op = {9'd0, a_sample_ff[7:0]};
      end else begin
         samp_op = {a_sample_ff[15], a_sample_ff};
      end
      amp_op       = {1'b0, amplitude_ff};
      prod_full    = samp_op * amp_op;
      b_product_in = prod_full[30:0];
   end

   // ---------------------------------------------------------------- quotient stage
   logic [46:0]        recip_prod;
   logic signed [30:0] biased;
   logic signed [15:0] q_s16;

   always_comb begin
      recip_prod = 47'(b_product_ff[22:0]) * 47'(wcmp_pkg::Recip255);
      biased     = b_product_ff + (b_product_ff[30] ? wcmp_pkg::TruncBias : 31'sd0);
      q_s16      = biased[30:15];
      if (format_ff == wcmp_pkg::FMT_U8) begin
         c_quot_in = {2'b00, recip_prod[wcmp_pkg::RecipShift+14:wcmp_pkg::RecipShift]};
      end else begin
         c_quot_in = {q_s16[15], q_s16};
      end
   end

   // ---------------------------------------------------------------- fold stage
   logic signed [17:0]                base_row, row_s, height_s;
   logic [wcmp_pkg::RowWidth-1:0]     row;
   logic [wcmp_pkg::RowWidth-1:0]     new_min, new_peak;
   logic [wcmp_pkg::SpcWidth:0]       spc_eff;
   logic [wcmp_pkg::ColCntWidth-1:0]  cols_eff;

   always_comb begin
      height_s = {6'd0, height_ff};
      if (format_ff == wcmp_pkg::FMT_U8) begin
         base_row = height_s;
      end else begin
         base_row = {7'd0, height_ff[wcmp_pkg::RowWidth-1:1]};
      end
      row_s = base_row - {c_quot_ff[16], c_quot_ff};
      if (row_s < 18'sd0) begin
         row = '0;
      end else if (row_s > height_s) begin
         row = height_ff;
      end else begin
         row = row_s[wcmp_pkg::RowWidth-1:0];
      end

      new_min  = (row < run_min_ff)  ? row : run_min_ff;
      new_peak = (row > run_peak_ff) ? row : run_peak_ff;

      // Treat zero samples per column and a zero column count as one; clamp column count to the counter size
      spc_eff = (spc_ff == '0) ? 17'd1 : {1'b0, spc_ff};
      if (col_count_ff == '0) begin
         cols_eff = 13'd1;
      end else if (col_count_ff > wcmp_pkg::MaxColumns) begin
         cols_eff = wcmp_pkg::MaxColumns;
      end else begin
         cols_eff = col_count_ff;
      end

      col_ends = ({1'b0, sample_in_col_ff} + 17'd1) >= spc_eff;
      col_last = ({1'b0, col_index_ff} + 13'd1) >= cols_eff;
      fold_go  = c_valid_ff && (!col_ends || !rsp_valid_ff || rsp_bus.ready);

      sample_in_col_in = sample_in_col_ff;
      col_index_in     = col_index_ff;
      run_min_in       = run_min_ff;
      run_peak_in      = run_peak_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      rsp_min_in       = rsp_min_ff;
      rsp_peak_in      = rsp_peak_ff;
      rsp_last_in      = rsp_last_ff;

      if (fold_go) begin
         if (col_ends) begin
            rsp_valid_in     = 1'b1;
            rsp_min_in       = new_min;
            rsp_peak_in      = new_peak;
            rsp_last_in      = col_last;
            sample_in_col_in = '0;
            col_index_in     = col_last ? '0 : col_index_ff + 12'd1;
            // Load the current height as the next column's starting minimum
            run_min_in       = height_ff;
            run_peak_in      = '0;
         end else begin
            sample_in_col_in = sample_in_col_ff + 16'd1;
            run_min_in       = new_min;
            run_peak_in      = new_peak;
         end
      end
   end

   // ---------------------------------------------------------------- state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff       <= 1'b0;
         b_valid_ff       <= 1'b0;
         c_valid_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         sample_in_col_ff <= '0;
         col_index_ff     <= '0;
         run_min_ff       <= wcmp_pkg::HeightReset;
         run_peak_ff      <= '0;
      end else begin
         a_valid_ff       <= a_valid_in;
         b_valid_ff       <= b_valid_in;
         c_valid_ff       <= c_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         sample_in_col_ff <= sample_in_col_in;
         col_index_ff     <= col_index_in;
         run_min_ff       <= run_min_in;
         run_peak_ff      <= run_peak_in;
      end
   end

   // Payload: stage registers load only when a transaction moves in; result fields load each cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_sample_ff <= req_bus.sample_word;
      end
      if (a_valid_ff && b_free) begin
         b_product_ff <= b_product_in;
      end
      if (b_valid_ff && c_free) begin
         c_quot_ff <= c_quot_in;
      end
      rsp_min_ff  <= rsp_min_in;
      rsp_peak_ff <= rsp_peak_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.column_min  = rsp_min_ff;
   assign rsp_bus.column_peak = rsp_peak_ff;
   assign rsp_bus.last_column = rsp_last_ff;

endmodule

FILE: tb/waveform_column_min_peak_tb.sv
// Testbench for waveform_column_min_peak: directed and random sample streams with
// per-column min/peak prediction, checked field by field on the result channel.
// Depends on wcmp_pkg and the wcmp_req_if, wcmp_rsp_if and wcmp_csr_if interfaces.
module waveform_column_min_peak_tb;

   localparam int StallLimit          = 2000;
   localparam int SettleCycles        = 8;
   localparam int RandomItemsPerPhase = 410;
   localparam int LimitItems          = 150;
   localparam int LongColumnItems     = 120;

   // Indexes past the last register; writes to them must leave everything unchanged
   localparam logic [wcmp_pkg::CsrIdxWidth-1:0] CsrSpareLow  = 3'd5;
   localparam logic [wcmp_pkg::CsrIdxWidth-1:0] CsrSpareMid  = 3'd6;
   localparam logic [wcmp_pkg::CsrIdxWidth-1:0] CsrSpareHigh = 3'd7;

   typedef struct packed {
      logic [wcmp_pkg::RowWidth-1:0] column_min;
      logic [wcmp_pkg::RowWidth-1:0] column_peak;
      logic                          last_column;
   } column_result_type;

   logic clock = 1'b0;
   logic reset;

   wcmp_req_if req_bus ();
   wcmp_rsp_if rsp_bus ();
   wcmp_csr_if csr_bus ();

   waveform_column_min_peak DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   int send_idle_pct;
   int recv_idle_pct;
   int error_count  = 0;
   int stall_cycles = 0;

   column_result_type pending_columns[$];

   // Predictor copy of the registers and the column fold
   logic [wcmp_pkg::RowWidth-1:0]    cfg_height;
   logic [wcmp_pkg::AmpWidth-1:0]    cfg_amplitude;
   logic [wcmp_pkg::SpcWidth-1:0]    cfg_spc;
   logic [wcmp_pkg::ColCntWidth-1:0] cfg_col_count;
   wcmp_pkg::sample_format_type      cfg_format;
   int unsigned                      fold_count;
   int unsigned                      col_pos;
   logic [wcmp_pkg::RowWidth-1:0]    fold_min;
   logic [wcmp_pkg::RowWidth-1:0]    fold_peak;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [wcmp_pkg::RowWidth-1:0] sample_row(
         input logic [wcmp_pkg::SampleWidth-1:0] w);
      longint h;
      longint a;
      longint s;
      longint r;
      h = longint'(cfg_height);
      a = longint'(cfg_amplitude);
      if (cfg_format == wcmp_pkg::FMT_U8) begin
         s = longint'(w[7:0]);
         r = h - (s * a) / 255;
      end else begin
         s = longint'($signed(w));
         r = h / 2 - (s * a) / 32768;
      end
      if (r > h) r = h;
      if (r < 0) r = 0;
      return r[wcmp_pkg::RowWidth-1:0];
   endfunction

   task automatic fold_sample(input logic [wcmp_pkg::SampleWidth-1:0] w);
      logic [wcmp_pkg::RowWidth-1:0] row;
      int unsigned                   spc;
      int unsigned                   cols;
      bit                            last;
      column_result_type             res;
      row  = sample_row(w);
      spc  = (cfg_spc == '0) ? 32'd1 : 32'(cfg_spc);
      cols = (cfg_col_count == '0) ? 32'd1 : 32'(cfg_col_count);
      if (cols > 32'(wcmp_pkg::MaxColumns)) cols = 32'(wcmp_pkg::MaxColumns);
      if (row < fold_min) fold_min = row;
      if (row > fold_peak) fold_peak = row;
      if (fold_count + 1 < spc) begin
         fold_count++;
      end else begin
         last = (col_pos + 1 >= cols);
         res.column_min  = fold_min;
         res.column_peak = fold_peak;
         res.last_column = last;
         pending_columns.push_back(res);
         fold_count = 0;
         col_pos    = last ? 32'd0 : ((col_pos + 1) & 32'hFFF);
         fold_min   = cfg_height;
         fold_peak  = '0;
      end
   endtask

   // Leaves valid high; the next call or settle() decides what follows
   task automatic send_sample(input logic [wcmp_pkg::SampleWidth-1:0] w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.sample_word <= w;
      do @(posedge clock); while (!req_bus.ready);
      fold_sample(w);
   endtask

   // Leaves valid high; the caller drops it after the last write of a batch
   task automatic write_reg(input logic [wcmp_pkg::CsrIdxWidth-1:0] idx,
                            input logic [wcmp_pkg::CsrDataWidth-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         wcmp_pkg::CSR_HEIGHT:    cfg_height    = data[wcmp_pkg::RowWidth-1:0];
         wcmp_pkg::CSR_AMPLITUDE: cfg_amplitude = data[wcmp_pkg::AmpWidth-1:0];
         wcmp_pkg::CSR_SPC:       cfg_spc       = data[wcmp_pkg::SpcWidth-1:0];
         wcmp_pkg::CSR_COL_COUNT: cfg_col_count = data[wcmp_pkg::ColCntWidth-1:0];
         wcmp_pkg::CSR_FORMAT:    cfg_format    = wcmp_pkg::sample_format_type'(data[0]);
         default: ;
      endcase
   endtask

   // Unused upper data bits are filled at random and must be ignored
   task automatic configure(input logic [wcmp_pkg::RowWidth-1:0] h,
                            input logic [wcmp_pkg::AmpWidth-1:0] amp,
                            input logic [wcmp_pkg::SpcWidth-1:0] spc,
                            input logic [wcmp_pkg::ColCntWidth-1:0] cc,
                            input wcmp_pkg::sample_format_type fmt);
      logic [wcmp_pkg::CsrDataWidth-1:0] fill;
      fill = 16'($urandom);
      fill[wcmp_pkg::RowWidth-1:0] = h;
      write_reg(wcmp_pkg::CSR_HEIGHT, fill);
      fill = 16'($urandom);
      fill[wcmp_pkg::AmpWidth-1:0] = amp;
      write_reg(wcmp_pkg::CSR_AMPLITUDE, fill);
      write_reg(wcmp_pkg::CSR_SPC, spc);
      fill = 16'($urandom);
      fill[wcmp_pkg::ColCntWidth-1:0] = cc;
      write_reg(wcmp_pkg::CSR_COL_COUNT, fill);
      fill = 16'($urandom);
      fill[0] = fmt;
      write_reg(wcmp_pkg::CSR_FORMAT, fill);
      csr_bus.valid <= 1'b0;
   endtask

   // Drop valid, wait for every expected column, then let the pipeline empty
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_columns.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic logic [wcmp_pkg::SampleWidth-1:0] pick_sample();
      logic [wcmp_pkg::SampleWidth-1:0] w;
      case ($urandom_range(7))
         0:       w = 16'h7FFF;
         1:       w = 16'h8000;
         2:       w = 16'($urandom_range(255));
         3:       w = 16'hFFFF - 16'($urandom_range(255));
         default: w = 16'($urandom);
      endcase
      return w;
   endfunction

   task automatic test_reset_defaults();
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      settle();
   endtask

   // Held minimum survives the write; the new height loads at the next column
   task automatic test_mid_column_write();
      configure(12'd20, 15'd50, 16'd6, 13'd640, wcmp_pkg::FMT_S16);
      send_sample(16'h4000);
      send_sample(16'hC000);
      send_sample(16'h0000);
      settle();
   endtask

   task automatic test_unsigned_rows();
      configure(12'd4095, 15'd32767, 16'd1, 13'd3, wcmp_pkg::FMT_U8);
      send_sample(16'h0000);
      send_sample(16'h00FF);
      send_sample(16'hFF00);
      send_sample(16'h807F);
      settle();
      configure(12'd4095, 15'd0, 16'd2, 13'd3, wcmp_pkg::FMT_U8);
      send_sample(16'h00FF);
      send_sample(16'h0001);
      settle();
   endtask

   task automatic test_signed_rows();
      configure(12'd4095, 15'd32767, 16'd1, 13'd0, wcmp_pkg::FMT_S16);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0001);
      send_sample(16'hFFFF);
      send_sample(16'hC000);
      settle();
   endtask

   task automatic test_zero_height();
      configure(12'd0, 15'd32767, 16'd0, 13'd2, wcmp_pkg::FMT_S16);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      settle();
   endtask

   task automatic test_spare_indexes();
      write_reg(CsrSpareLow, 16'hFFFF);
      write_reg(CsrSpareMid, 16'hFFFF);
      write_reg(CsrSpareHigh, 16'hFFFF);
      csr_bus.valid <= 1'b0;
      send_sample(16'h8001);
      send_sample(16'h00FF);
      settle();
   endtask

   // Full-size and oversized column counts: no column may be marked last early
   task automatic test_column_count_limits();
      configure(12'd4095, 15'd20000, 16'd1, wcmp_pkg::MaxColumns, wcmp_pkg::FMT_S16);
      repeat (LimitItems) send_sample(pick_sample());
      settle();
      configure(12'd3000, 15'd100, 16'd1, 13'h1FFF, wcmp_pkg::FMT_U8);
      repeat (LimitItems) send_sample(pick_sample());
      settle();
   endtask

   // Largest column length: the column stays open across every sample sent
   task automatic test_longest_column();
      configure(12'd1234, 15'd777, 16'hFFFF, 13'd1, wcmp_pkg::FMT_S16);
      repeat (LongColumnItems) send_sample(pick_sample());
      settle();
   endtask

   task automatic random_configure();
      logic [wcmp_pkg::RowWidth-1:0]    h;
      logic [wcmp_pkg::AmpWidth-1:0]    amp;
      logic [wcmp_pkg::SpcWidth-1:0]    spc;
      logic [wcmp_pkg::ColCntWidth-1:0] cc;
      case ($urandom_range(9))
         0:       h = '0;
         1:       h = 12'd4095;
         2:       h = 12'($urandom_range(1, 200));
         default: h = 12'($urandom);
      endcase
      case ($urandom_range(9))
         0:       amp = '0;
         1:       amp = 15'd32767;
         default: amp = 15'($urandom);
      endcase
      case ($urandom_range(9))
         0:       spc = '0;
         1:       spc = 16'($urandom_range(9, 40));
         default: spc = 16'($urandom_range(1, 8));
      endcase
      case ($urandom_range(9))
         0:       cc = '0;
         1:       cc = wcmp_pkg::MaxColumns;
         2:       cc = 13'h1FFF;
         default: cc = 13'($urandom_range(1, 6));
      endcase
      configure(h, amp, spc, cc, wcmp_pkg::sample_format_type'($urandom_range(1)));
   endtask

   task automatic test_random_stream();
      int sent;
      int burst;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 22; recv_idle_pct = 82; end
            1: begin send_idle_pct = 82; recv_idle_pct = 22; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         sent = 0;
         while (sent < RandomItemsPerPhase) begin
            settle();
            random_configure();
            burst = $urandom_range(20, 80);
            repeat (burst) send_sample(pick_sample());
            sent += burst;
         end
      end
   endtask

   always @(posedge clock) begin
      column_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_columns.size() == 0) begin
            $error("column result with none expected: min %0d peak %0d last %0d",
                   rsp_bus.column_min, rsp_bus.column_peak, rsp_bus.last_column);
            error_count++;
         end else begin
            want = pending_columns.pop_front();
            if (rsp_bus.column_min !== want.column_min) begin
               $error("column_min: expected %0d, actual %0d",
                      want.column_min, rsp_bus.column_min);
               error_count++;
            end
            if (rsp_bus.column_peak !== want.column_peak) begin
               $error("column_peak: expected %0d, actual %0d",
                      want.column_peak, rsp_bus.column_peak);
               error_count++;
            end
            if (rsp_bus.last_column !== want.last_column) begin
               $error("last_column: expected %0d, actual %0d",
                      want.last_column, rsp_bus.last_column);
               error_count++;
            end
         end
      end
   end

   // Count cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.sample_word = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = '0;
      csr_bus.data        = '0;
      send_idle_pct       = 22;
      recv_idle_pct       = 82;
      cfg_height          = wcmp_pkg::HeightReset;
      cfg_amplitude       = wcmp_pkg::AmplitudeReset;
      cfg_spc             = wcmp_pkg::SpcReset;
      cfg_col_count       = wcmp_pkg::ColCountReset;
      cfg_format          = wcmp_pkg::sample_format_type'(wcmp_pkg::FormatReset);
      fold_count          = 0;
      col_pos             = 0;
      fold_min            = wcmp_pkg::HeightReset;
      fold_peak           = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_mid_column_write();
      test_unsigned_rows();
      test_signed_rows();
      test_zero_height();
      test_spare_indexes();
      test_column_count_limits();
      test_longest_column();
      test_random_stream();
      settle();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
